// ===== hdl/serial_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared check macros; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr check failed");
// Next-cycle implication, disabled during reset
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr check failed");
`else
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Widths, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 7;
    localparam int CFG_IDX_W  = 2;
    // byte count plus headroom, and the clamped limit, fit in this width
    localparam int LIMIT_W    = BYTE_W + 1;

    localparam int FRAME_BYTES_DEF = 128;

    localparam logic [LIMIT_W-1:0] HEADROOM        = LIMIT_W'(5);
    localparam logic [BYTE_W-1:0]  FRAME_LIMIT_RST = BYTE_W'(100);

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_BYTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 2'd3;

    typedef struct packed {
        logic                store_en;
        logic [OFFSET_W-1:0] store_offset;
        logic [BYTE_W-1:0]   store_byte;
        logic                frame_done;
        logic [BYTE_W-1:0]   frame_length;
        logic [BYTE_W-1:0]   frame_addr;
        logic [BYTE_W-1:0]   frame_index;
        logic [BYTE_W-1:0]   frame_size;
    } t_result;

endpackage

// ===== hdl/sfr_rx_if.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver byte channel
// Valid/ready channel that carries one received serial byte.
// ----------------------------------------------------------------------------
interface sfr_rx_if import sfr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== hdl/sfr_res_if.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver result channel
// Valid/ready channel that carries the frame store write and frame status.
// ----------------------------------------------------------------------------
interface sfr_res_if import sfr_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                store_en;
    logic [OFFSET_W-1:0] store_offset;
    logic [BYTE_W-1:0]   store_byte;
    logic                frame_done;
    logic [BYTE_W-1:0]   frame_length;
    logic [BYTE_W-1:0]   frame_addr;
    logic [BYTE_W-1:0]   frame_index;
    logic [BYTE_W-1:0]   frame_size;

    modport source (
        output valid, input ready,
        output store_en, output store_offset, output store_byte,
        output frame_done, output frame_length, output frame_addr,
        output frame_index, output frame_size
    );
    modport sink (
        input valid, output ready,
        input store_en, input store_offset, input store_byte,
        input frame_done, input frame_length, input frame_addr,
        input frame_index, input frame_size
    );

endinterface

// ===== hdl/serial_frame_receiver.sv =====
// Output: the result of each transferred byte is registered before it is shown.
// Throughput: one byte per cycle; the only limit is the single result
// register, which accepts a new byte in the same cycle its contents leave.
// Reset: synchronous, active low; returns the parser to hunting, clears the
// byte count, held header fields and result valid, and loads the register
// reset values.
// ----------------------------------------------------------------------------
// Serial frame receiver
// Byte-at-a-time frame parser driving a frame store write port and a
// frame-complete flag with the header fields.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_defines.svh"

module serial_frame_receiver import sfr_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    sfr_rx_if.sink               i_rx,
    sfr_res_if.source            o_res
);

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_ADDR  = 4'd1,
        PH_INDEX = 4'd2,
        PH_SIZE  = 4'd3,
        PH_TOKEN = 4'd4,
        PH_DATA  = 4'd5,
        PH_CRCL  = 4'd6,
        PH_CRCH  = 4'd7,
        PH_END   = 4'd8
    } t_phase;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(FRAME_BYTES);

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_token_byte;
    logic [BYTE_W-1:0] r_end_byte;
    logic [BYTE_W-1:0] r_frame_limit;

    t_phase            r_phase,        n_phase;
    logic [BYTE_W-1:0] r_byte_count,   n_byte_count;
    logic [BYTE_W-1:0] r_payload_left, n_payload_left;
    logic [BYTE_W-1:0] r_held_addr,    n_held_addr;
    logic [BYTE_W-1:0] r_held_index,   n_held_index;
    logic [BYTE_W-1:0] r_held_size,    n_held_size;
    t_result           r_res,          n_res;
    logic              r_res_vld;

    logic               w_in_xfer;
    logic [BYTE_W-1:0]  w_count_inc;
    logic [LIMIT_W-1:0] w_limit;
    logic               w_too_long;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= '0;
            r_token_byte  <= '0;
            r_end_byte    <= '0;
            r_frame_limit <= FRAME_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_BYTE:  r_start_byte  <= i_cfg_data;
                REG_TOKEN_BYTE:  r_token_byte  <= i_cfg_data;
                REG_END_BYTE:    r_end_byte    <= i_cfg_data;
                REG_FRAME_LIMIT: r_frame_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Take a new byte whenever the result register is empty or draining
    assign i_rx.ready = !r_res_vld || o_res.ready;
    assign w_in_xfer  = i_rx.valid && i_rx.ready;

    assign w_count_inc = r_byte_count + BYTE_W'(1);
    assign w_limit     = ({1'b0, r_frame_limit} > LIMIT_MAX) ? LIMIT_MAX
                                                             : {1'b0, r_frame_limit};
    assign w_too_long  = ({1'b0, w_count_inc} + HEADROOM) > w_limit;

    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_payload_left = r_payload_left;
        n_held_addr    = r_held_addr;
        n_held_index   = r_held_index;
        n_held_size    = r_held_size;
        n_res          = '0;

        case (r_phase)
            PH_HUNT: begin
                n_res.store_en   = 1'b1;
                n_res.store_byte = r_start_byte;
                n_byte_count     = BYTE_W'(1);
                if (i_rx.rx_byte == r_start_byte) begin
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                n_held_addr = i_rx.rx_byte;
                n_phase     = PH_INDEX;
            end
            PH_INDEX: begin
                n_held_index = i_rx.rx_byte;
                n_phase      = PH_SIZE;
            end
            PH_SIZE: begin
                n_held_size    = i_rx.rx_byte;
                n_payload_left = i_rx.rx_byte;
                n_phase        = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (i_rx.rx_byte == r_token_byte) begin
                    n_phase = (r_payload_left != '0) ? PH_DATA : PH_CRCL;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                n_payload_left = r_payload_left - BYTE_W'(1);
                if (n_payload_left == '0) begin
                    n_phase = PH_CRCL;
                end
                // drop an oversized frame, even on its last payload byte
                if (w_too_long) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CRCL: n_phase = PH_CRCH;
            PH_CRCH: n_phase = PH_END;
            PH_END:  n_phase = PH_HUNT;
            default: n_phase = PH_HUNT;
        endcase

        // Every phase past hunting stores the byte at the running count,
        // except a token that does not match
        if (r_phase != PH_HUNT && r_phase <= PH_END &&
            !(r_phase == PH_TOKEN && i_rx.rx_byte != r_token_byte)) begin
            n_res.store_en     = 1'b1;
            n_res.store_offset = r_byte_count[OFFSET_W-1:0];
            n_res.store_byte   = i_rx.rx_byte;
            n_byte_count       = w_count_inc;
        end

        if (r_phase == PH_END && i_rx.rx_byte == r_end_byte) begin
            n_res.frame_done   = 1'b1;
            n_res.frame_length = w_count_inc;
            n_res.frame_addr   = r_held_addr;
            n_res.frame_index  = r_held_index;
            n_res.frame_size   = r_held_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_byte_count   <= '0;
            r_payload_left <= '0;
            r_held_addr    <= '0;
            r_held_index   <= '0;
            r_held_size    <= '0;
            r_res_vld      <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_phase        <= n_phase;
                r_byte_count   <= n_byte_count;
                r_payload_left <= n_payload_left;
                r_held_addr    <= n_held_addr;
                r_held_index   <= n_held_index;
                r_held_size    <= n_held_size;
                r_res          <= n_res;
                r_res_vld      <= 1'b1;
            end else if (o_res.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_res_vld;
    assign o_res.store_en     = r_res.store_en;
    assign o_res.store_offset = r_res.store_offset;
    assign o_res.store_byte   = r_res.store_byte;
    assign o_res.frame_done   = r_res.frame_done;
    assign o_res.frame_length = r_res.frame_length;
    assign o_res.frame_addr   = r_res.frame_addr;
    assign o_res.frame_index  = r_res.frame_index;
    assign o_res.frame_size   = r_res.frame_size;

    `SFR_ASSERT_IMP(a_done_has_write, i_clk, i_rst_n,
        o_res.valid && o_res.frame_done, o_res.store_en)
    `SFR_ASSERT_NXT(a_bad_token_no_write, i_clk, i_rst_n,
        w_in_xfer && r_phase == PH_TOKEN && i_rx.rx_byte != r_token_byte,
        o_res.valid && !o_res.store_en && r_phase == PH_HUNT)
    `SFR_ASSERT_IMP(a_count_in_frame, i_clk, i_rst_n,
        r_phase != PH_HUNT, r_byte_count != '0)

endmodule
